// ===== rtl/core/lislt_pkg.sv =====
package lislt_pkg;

	localparam int unsigned LEN_W   = 11;
	localparam int unsigned VALUE_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WRITE
	} lislt_state_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             end_of_sequence;
		logic             overflow;
	} lislt_result_t;

endpackage

// ===== rtl/core/lis_length_tracker.sv =====
// A transaction makes P binary-search probes of the tail table, P being at most
// floor(log2(count)) + 1 (11 at a depth of 1024), then writes back and loads its result.
// The single compare unit and the table's one read port take one probe per cycle.
// The next item is taken once the last one leaves its write step, even while a result waits.
// Reset clears the sequencer, the entry count and the overflow flag; the tail table
// holds no reset value and needs no clearing pass.
module lis_length_tracker #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [lislt_pkg::VALUE_W-1:0] value,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lislt_pkg::LEN_W-1:0]          length,
	output logic                                 end_of_sequence,
	output logic                                 overflow
);

	import lislt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;
	logic                res_load;
	lislt_result_t       res;
	lislt_result_t       res_q;
	logic                out_valid_q;
	logic                out_hold;

	assign out_hold = out_valid_q && !out_ready;

	lislt_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_tail_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lislt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.last     (last),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_hold (out_hold),
		.res_load (res_load),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign length          = res_q.length;
	assign end_of_sequence = res_q.end_of_sequence;
	assign overflow        = res_q.overflow;

endmodule

// ===== rtl/core/lislt_ram.sv =====
module lislt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/lislt_ctrl.sv =====
module lislt_ctrl #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [lislt_pkg::VALUE_W-1:0] value,
	input  logic                              last,
	output logic                              ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]    ram_waddr,
	output logic [lislt_pkg::VALUE_W-1:0]     ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(TABLE_DEPTH)-1:0]    ram_raddr,
	input  logic [lislt_pkg::VALUE_W-1:0]     ram_rdata,
	input  logic                              out_hold,
	output logic                              res_load,
	output lislt_pkg::lislt_result_t          res
);

	import lislt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	lislt_state_t               state_q, state_d;
	logic signed [VALUE_W-1:0]  key_q;
	logic                       last_q;
	logic [CW-1:0]              lo_q, lo_d;
	logic [CW-1:0]              hi_q, hi_d;
	logic [AW-1:0]              mid_q, mid_d;
	logic [CW-1:0]              count_q, count_d;
	logic                       ovf_q, ovf_d;
	logic                       less;
	logic [CW-1:0]              span;
	logic [CW-1:0]              cnt_new;
	logic                       ovf_new;

	// The shared compare unit: one probe of the tail table per cycle.
	assign less = $signed(ram_rdata) < key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q  <= value;
			last_q <= last;
		end
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		span      = '0;
		count_d   = count_q;
		ovf_d     = ovf_q;
		ram_we    = 1'b0;
		ram_waddr = AW'(lo_q);
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = mid_q;
		res_load  = 1'b0;
		cnt_new   = count_q;
		ovf_new   = ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				lo_d     = '0;
				hi_d     = count_q;
				mid_d    = AW'(count_q >> 1);
				if (in_valid) begin
					ram_re    = (count_q != '0);
					ram_raddr = AW'(count_q >> 1);
					state_d   = (count_q != '0) ? ST_SEARCH : ST_WRITE;
				end
			end
			ST_SEARCH: begin
				if (less) begin
					lo_d = CW'(mid_q) + CW'(1);
				end else begin
					hi_d = CW'(mid_q);
				end
				span  = hi_d - lo_d;
				mid_d = AW'(lo_d + (span >> 1));
				if (lo_d < hi_d) begin
					ram_re    = 1'b1;
					ram_raddr = mid_d;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (lo_q < count_q) begin
					ram_waddr = AW'(lo_q);
				end else if (count_q < CW'(TABLE_DEPTH)) begin
					ram_waddr = AW'(count_q);
					cnt_new   = count_q + CW'(1);
				end else begin
					ovf_new = 1'b1;
				end
				// The result register must be free before the table is touched.
				if (!out_hold) begin
					res_load = 1'b1;
					ram_we   = (lo_q < count_q) || (count_q < CW'(TABLE_DEPTH));
					count_d  = last_q ? '0 : cnt_new;
					ovf_d    = last_q ? 1'b0 : ovf_new;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.length          = LEN_W'(cnt_new);
	assign res.end_of_sequence = last_q;
	assign res.overflow        = ovf_new;

endmodule

// ===== sim/tb_lis_length_tracker.sv =====
module tb_lis_length_tracker;
	import lislt_pkg::*;

	localparam int unsigned DEPTH       = 1024;
	localparam int          CYCLE_LIMIT = 800000;
	localparam int          RAND_ITEMS  = 1000;
	localparam int          DRAIN_WAIT  = 30;

	typedef enum int {
		SEQ_WIDE,
		SEQ_NARROW,
		SEQ_RISING
	} seq_kind_t;

	// One row of directed stimulus: reps values starting at first, spaced by step.
	// Where typed is set, want is the expected result of the final value of the row.
	typedef struct {
		logic signed [VALUE_W-1:0] first;
		int                        step;
		int                        reps;
		logic                      last;
		logic                      typed;
		lislt_result_t             want;
	} stim_row_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic signed [VALUE_W-1:0] value     = '0;
	logic                      last      = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [LEN_W-1:0]          length;
	logic                      end_of_sequence;
	logic                      overflow;

	// Side information travelling with the payload, seen by the monitor on acceptance.
	logic                      row_typed = 1'b0;
	lislt_result_t             row_want  = '0;

	// Predictor state: smallest tail per subsequence length.
	logic signed [VALUE_W-1:0] tails [DEPTH];
	int                        tail_count = 0;
	logic                      full_dropped = 1'b0;

	lislt_result_t             lis_expected [$];
	lislt_result_t             got_result;
	lislt_result_t             want_result;
	int                        mismatch_count = 0;
	int                        cycle_count = 0;
	int                        gap_max = 0;
	int                        burst_left = 0;
	int                        rx_phase = 0;
	int                        rx_stall_pct = 0;

	lis_length_tracker #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.value          (value),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.length         (length),
		.end_of_sequence(end_of_sequence),
		.overflow       (overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lislt_result_t lis_take(input logic signed [VALUE_W-1:0] v,
			input logic is_last);
		int            lo;
		int            hi;
		int            mid;
		lislt_result_t r;
		lo = 0;
		hi = tail_count;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (tails[mid] < v)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < tail_count) begin
			tails[lo] = v;
		end else if (tail_count < DEPTH) begin
			tails[tail_count] = v;
			tail_count++;
		end else begin
			full_dropped = 1'b1;
		end
		r.length          = LEN_W'(tail_count);
		r.end_of_sequence = is_last;
		r.overflow        = full_dropped;
		if (is_last) begin
			tail_count   = 0;
			full_dropped = 1'b0;
		end
		return r;
	endfunction

	// The receiver changes its own stall rate, among 0, 25, 60 and 90 percent, as rx_phase counts.
	always @(negedge clk) begin
		if (rx_phase % 257 == 0) begin
			case ($urandom_range(0, 3))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 25;
				2: rx_stall_pct = 60;
				default: rx_stall_pct = 90;
			endcase
		end
		rx_phase++;
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_result = '{length, end_of_sequence, overflow};
				if (lis_expected.size() == 0) begin
					$display("%0t: unexpected result length %0d eos %0b overflow %0b",
						$time, got_result.length, got_result.end_of_sequence,
						got_result.overflow);
					mismatch_count++;
				end else begin
					want_result = lis_expected.pop_front();
					if (got_result.length !== want_result.length) begin
						$display("%0t: length expected %0d actual %0d", $time,
							want_result.length, got_result.length);
						mismatch_count++;
					end
					if (got_result.end_of_sequence !== want_result.end_of_sequence) begin
						$display("%0t: end_of_sequence expected %0b actual %0b", $time,
							want_result.end_of_sequence, got_result.end_of_sequence);
						mismatch_count++;
					end
					if (got_result.overflow !== want_result.overflow) begin
						$display("%0t: overflow expected %0b actual %0b", $time,
							want_result.overflow, got_result.overflow);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				want_result = lis_take(value, last);
				if (row_typed)
					want_result = row_want;
				lis_expected = {lis_expected, want_result};
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic feed(input logic signed [VALUE_W-1:0] v, input logic is_last,
			input logic typed, input lislt_result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid  <= 1'b1;
		value     <= v;
		last      <= is_last;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Holds the sender off until every outstanding result has been collected.
	task automatic drain_results();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (lis_expected.size() != 0);
	endtask

	task automatic run_sequence(input int n, input seq_kind_t kind);
		logic signed [VALUE_W-1:0] v;
		logic                      is_last;
		int                        i;
		v = $signed($urandom_range(0, 2000)) - 1000;
		for (i = 0; i < n; i++) begin
			is_last = (i == n - 1);
			case (kind)
				SEQ_NARROW: v = $signed($urandom_range(0, 63)) - 32;
				SEQ_RISING: v = v + $signed($urandom_range(0, 40)) - 8;
				default: begin
					v = $urandom;
					is_last = is_last || ($urandom_range(0, 15) == 0);
				end
			endcase
			feed(v, is_last, 1'b0, '0);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("lis_length_tracker verification failed");
		$finish;
	end

	initial begin
		stim_row_t rows [17];
		int        r;
		int        k;
		int        n;
		int        rand_done;
		logic      mid_drained;
		seq_kind_t kind;

		rows = '{
			'{32'sd0,           0, 1,    1'b1, 1'b1, '{11'd1,    1'b1, 1'b0}},
			'{32'sh8000_0000,   0, 1,    1'b0, 1'b1, '{11'd1,    1'b0, 1'b0}},
			'{32'sh7FFF_FFFF,   0, 1,    1'b0, 1'b1, '{11'd2,    1'b0, 1'b0}},
			'{32'sh7FFF_FFFF,   0, 1,    1'b0, 1'b1, '{11'd2,    1'b0, 1'b0}},
			'{32'sh8000_0000,   0, 1,    1'b1, 1'b1, '{11'd2,    1'b1, 1'b0}},
			'{32'sd5,           0, 1,    1'b0, 1'b1, '{11'd1,    1'b0, 1'b0}},
			'{32'sd4,           0, 1,    1'b0, 1'b1, '{11'd1,    1'b0, 1'b0}},
			'{32'sd3,           0, 1,    1'b1, 1'b1, '{11'd1,    1'b1, 1'b0}},
			'{32'sh5555_5555,   0, 1,    1'b0, 1'b0, '0},
			'{32'shAAAA_AAAA,   0, 1,    1'b0, 1'b0, '0},
			'{-32'sd1,          0, 1,    1'b0, 1'b0, '0},
			'{32'sd0,           0, 1,    1'b0, 1'b0, '0},
			'{32'sd1,           0, 1,    1'b1, 1'b0, '0},
			// A strictly rising run that fills the table and then tries to grow past it.
			'{-32'sd1000,       1, 1030, 1'b0, 1'b1, '{11'd1024, 1'b0, 1'b1}},
			// With the table full, an equal value still replaces the smallest tail.
			'{-32'sd1000,       0, 1,    1'b0, 1'b1, '{11'd1024, 1'b0, 1'b1}},
			'{32'sd100000,      0, 1,    1'b1, 1'b1, '{11'd1024, 1'b1, 1'b1}},
			'{32'sd7,           0, 1,    1'b1, 1'b1, '{11'd1,    1'b1, 1'b0}}
		};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_max = 3;
		for (r = 0; r < 17; r++) begin
			for (k = 0; k < rows[r].reps; k++) begin
				feed(rows[r].first + k * rows[r].step,
					(k == rows[r].reps - 1) ? rows[r].last : 1'b0,
					rows[r].typed && (k == rows[r].reps - 1), rows[r].want);
			end
		end
		drain_results();

		// A long well-formed rising sequence first, then a mix of shorter ones.
		gap_max = 0;
		run_sequence(300, SEQ_RISING);
		rand_done   = 300;
		mid_drained = 1'b0;
		while (rand_done < RAND_ITEMS) begin
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 4))
					0, 1: gap_max = 0;
					2: gap_max = 2;
					3: gap_max = 6;
					default: gap_max = 15;
				endcase
			end
			kind = seq_kind_t'($urandom_range(0, 2));
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
			run_sequence(n, kind);
			rand_done += n;
			if (!mid_drained && rand_done > RAND_ITEMS / 2) begin
				drain_results();
				mid_drained = 1'b1;
			end
		end

		drain_results();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0 && lis_expected.size() == 0) begin
			$display("lis_length_tracker verification clean");
		end else begin
			$display("lis_length_tracker verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lislt_pkg.sv
rtl/core/lislt_ram.sv
rtl/core/lislt_ctrl.sv
rtl/core/lis_length_tracker.sv
sim/tb_lis_length_tracker.sv
